// ===== design/ctt_pkg.sv =====
// Package for the TCP connection tracking table.
// Holds the row, packet and chain types, operation and state codes, and helpers.
// No dependencies.
package ctt_pkg;

	localparam int unsigned TABLE_ROWS_DEF = 64;

	localparam logic [15:0] PORT_HTTP     = 16'd80;
	localparam logic [15:0] PORT_FTP      = 16'd21;
	localparam logic [15:0] PORT_FTP_DATA = 16'd20;
	localparam logic [15:0] PORT_SMTP     = 16'd25;

	localparam logic [1:0] OP_ADD      = 2'd0;
	localparam logic [1:0] OP_CHECK    = 2'd1;
	localparam logic [1:0] OP_LOOKUP   = 2'd2;
	localparam logic [1:0] OP_RESERVED = 2'd3;

	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_FULL     = 2'd1;
	localparam logic [1:0] STATUS_NOTFOUND = 2'd2;

	localparam logic [2:0] ST_CLOSED       = 3'd0;
	localparam logic [2:0] ST_SYN_SENT     = 3'd1;
	localparam logic [2:0] ST_SYNACK       = 3'd2;
	localparam logic [2:0] ST_ESTABLISHED  = 3'd3;
	localparam logic [2:0] ST_FINWAIT      = 3'd4;
	localparam logic [2:0] ST_FINWAIT2     = 3'd5;
	localparam logic [2:0] ST_FINACK       = 3'd6;
	localparam logic [2:0] ST_EXPECTED_FTP = 3'd7;

	typedef enum logic [1:0] {
		FSM_IDLE,
		FSM_EXEC,
		FSM_COMPACT
	} fsm_t;

	typedef struct packed {
		logic [31:0] src_ip;
		logic [31:0] dst_ip;
		logic [15:0] sport;
		logic [15:0] dport;
		logic [2:0]  tcp_state;
		logic [31:0] timestamp;
		logic [7:0]  rule;
	} row_t;

	typedef struct packed {
		logic valid;
		logic hole;
		row_t row;
	} slot_t;

	typedef struct packed {
		logic        check_en;
		logic        lookup_en;
		logic        compact_en;
		logic        plain;
		logic        syn;
		logic        fin;
		logic        rst;
		logic        direction;
		logic [31:0] src_ip;
		logic [31:0] dst_ip;
		logic [15:0] sport;
		logic [15:0] dport;
		logic [31:0] now;
	} ctl_t;

	typedef struct packed {
		logic        hole_pre;
		logic        found_pre;
		logic        open_acc;
		logic [31:0] peer_ip;
		logic [15:0] peer_port;
	} fwd_t;

	typedef struct packed {
		logic       act_later;
		logic [7:0] rule_acc;
	} bwd_t;

	function automatic logic well_known(input logic [15:0] p);
		return (p == PORT_HTTP) || (p == PORT_FTP) || (p == PORT_FTP_DATA) ||
			(p == PORT_SMTP);
	endfunction

endpackage

// ===== design/ctt_cell.sv =====
// One row cell of the connection table chain.
// Holds a row, matches it against the broadcast word and shifts toward the head.
// Depends on ctt_pkg.
module ctt_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  ctt_pkg::ctl_t   ctl,
	input  logic            load,
	input  ctt_pkg::row_t   load_row,
	input  ctt_pkg::slot_t  nxt_slot,
	output ctt_pkg::slot_t  slot,
	input  ctt_pkg::fwd_t   fwd_in,
	output ctt_pkg::fwd_t   fwd_out,
	input  ctt_pkg::bwd_t   bwd_in,
	output ctt_pkg::bwd_t   bwd_out
);

	logic           valid_q;
	logic           hole_q;
	ctt_pkg::row_t  row_q;
	logic           fwd_m;
	logic           rev_m;
	logic           remove;
	logic           match;
	logic [2:0]     st1;
	logic [2:0]     nst;
	logic           trans;
	logic           act;
	logic           opn;
	logic           sy;
	logic           fi;
	logic           none;
	logic           lk_hit;
	logic           lk_take;
	logic           shift;

	assign slot = {valid_q, hole_q, row_q};

	always_comb begin
		sy   = ctl.syn && !ctl.fin;
		fi   = ctl.fin && !ctl.syn;
		none = !ctl.syn && !ctl.fin;
		fwd_m = (row_q.src_ip == ctl.src_ip) && (row_q.dst_ip == ctl.dst_ip) &&
			(row_q.sport == ctl.sport) && (row_q.dport == ctl.dport);
		rev_m = (row_q.src_ip == ctl.dst_ip) && (row_q.dst_ip == ctl.src_ip) &&
			(row_q.sport == ctl.dport) && (row_q.dport == ctl.sport);
		remove = valid_q && fwd_m && !rev_m &&
			(row_q.tcp_state == ctt_pkg::ST_CLOSED);
		match = valid_q && !remove && (fwd_m || (ctl.plain && rev_m));
		st1 = ctl.rst ? ctt_pkg::ST_CLOSED : row_q.tcp_state;
		nst = st1;
		trans = 1'b0;
		priority if (st1 == ctt_pkg::ST_EXPECTED_FTP && sy) begin
			nst = ctt_pkg::ST_SYN_SENT;
			trans = 1'b1;
		end else if (st1 == ctt_pkg::ST_SYN_SENT && sy) begin
			nst = ctt_pkg::ST_SYNACK;
			trans = 1'b1;
		end else if (st1 == ctt_pkg::ST_SYNACK && none) begin
			nst = ctt_pkg::ST_ESTABLISHED;
			trans = 1'b1;
		end else if (st1 == ctt_pkg::ST_ESTABLISHED && fi) begin
			nst = ctt_pkg::ST_FINWAIT;
			trans = 1'b1;
		end else if ((st1 == ctt_pkg::ST_FINWAIT || st1 == ctt_pkg::ST_FINWAIT2) && fi) begin
			nst = ctt_pkg::ST_FINACK;
			trans = 1'b1;
		end else if (st1 == ctt_pkg::ST_FINWAIT && none) begin
			nst = ctt_pkg::ST_FINWAIT2;
			trans = 1'b1;
		end else if (st1 == ctt_pkg::ST_FINACK && none) begin
			nst = ctt_pkg::ST_CLOSED;
			trans = 1'b1;
		end else if (st1 == ctt_pkg::ST_ESTABLISHED && none) begin
			trans = 1'b1;
		end
		act = ctl.check_en && match && (ctl.rst || trans);
		opn = ctl.check_en && match && (st1 == ctt_pkg::ST_ESTABLISHED) && none;

		lk_hit = valid_q && (ctl.direction ?
			((row_q.dst_ip == ctl.src_ip) && (row_q.dport == ctl.sport)) :
			((row_q.src_ip == ctl.src_ip) && (row_q.sport == ctl.sport)));
		lk_take = ctl.lookup_en && lk_hit && !fwd_in.found_pre;

		shift = ctl.compact_en && (fwd_in.hole_pre || hole_q);

		fwd_out.hole_pre  = fwd_in.hole_pre || hole_q;
		fwd_out.found_pre = fwd_in.found_pre || lk_take;
		fwd_out.open_acc  = fwd_in.open_acc || opn;
		fwd_out.peer_ip   = fwd_in.peer_ip |
			(lk_take ? (ctl.direction ? row_q.src_ip : row_q.dst_ip) : 32'd0);
		fwd_out.peer_port = fwd_in.peer_port |
			(lk_take ? (ctl.direction ? row_q.sport : row_q.dport) : 16'd0);

		bwd_out.act_later = bwd_in.act_later || act;
		bwd_out.rule_acc  = bwd_in.rule_acc |
			((act && !bwd_in.act_later) ? row_q.rule : 8'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			hole_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
			hole_q <= 1'b0;
		end else if (shift) begin
			valid_q <= nxt_slot.valid;
			hole_q <= nxt_slot.hole;
		end else if (ctl.check_en && remove) begin
			hole_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			row_q <= load_row;
		end else if (shift) begin
			row_q <= nxt_slot.row;
		end else if (act) begin
			row_q.tcp_state <= nst;
			row_q.timestamp <= ctl.now;
		end
	end

endmodule

// ===== design/tcp_connection_tracking_table.sv =====
// Top level of the TCP connection tracking table: a chain of row cells and its sequencer.
// Depends on ctt_pkg and ctt_cell.
//
//  channel   | handshake          | ports
//  ----------+--------------------+-------------------------------------------------------
//  command   | start, busy        | op, src_ip, dst_ip, sport, dport, flags, ...
//  result    | done (strobe)      | verdict, matched_rule, open_data, status, peer_*, row_count
//
// A word passes from acceptance through the execute state and the compaction state to its
// done strobe; each closed row that a check removes costs one shift of the cell chain.
// Reset empties the table at once. The done strobe stands for one cycle and cannot be held off.
module tcp_connection_tracking_table #(
	parameter int unsigned TABLE_ROWS = ctt_pkg::TABLE_ROWS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  op,
	input  logic [31:0] src_ip,
	input  logic [31:0] dst_ip,
	input  logic [15:0] sport,
	input  logic [15:0] dport,
	input  logic        syn_flag,
	input  logic        fin_flag,
	input  logic        rst_flag,
	input  logic [2:0]  initial_state,
	input  logic [7:0]  rule_index,
	input  logic [31:0] now_seconds,
	input  logic        direction,
	output logic        done,
	output logic        verdict,
	output logic [7:0]  matched_rule,
	output logic        open_data,
	output logic [1:0]  status,
	output logic [31:0] peer_ip,
	output logic [15:0] peer_port,
	output logic [6:0]  row_count
);

	localparam int unsigned CW = $clog2(TABLE_ROWS + 1);

	ctt_pkg::fsm_t  state_q;
	ctt_pkg::fsm_t  state_d;
	logic [1:0]     op_q;
	logic [2:0]     init_q;
	logic [7:0]     rule_q;
	ctt_pkg::ctl_t  cmd_q;
	ctt_pkg::ctl_t  ctl;
	logic [CW-1:0]  count_q;
	logic           full;
	logic           add_en;
	logic           hole_any;
	logic           done_q;
	logic           verdict_q;
	logic [7:0]     rule_out_q;
	logic           open_q;
	logic [1:0]     status_q;
	logic [31:0]    peer_ip_q;
	logic [15:0]    peer_port_q;
	ctt_pkg::row_t  new_row;

	ctt_pkg::slot_t slots [TABLE_ROWS+1];
	ctt_pkg::fwd_t  fwds  [TABLE_ROWS+1];
	ctt_pkg::bwd_t  bwds  [TABLE_ROWS+1];

	assign busy = (state_q != ctt_pkg::FSM_IDLE);
	assign full = (count_q == CW'(TABLE_ROWS));
	assign hole_any = fwds[TABLE_ROWS].hole_pre;
	assign add_en = (state_q == ctt_pkg::FSM_EXEC) && (op_q == ctt_pkg::OP_ADD) && !full;

	always_comb begin
		ctl = cmd_q;
		ctl.check_en = (state_q == ctt_pkg::FSM_EXEC) && (op_q == ctt_pkg::OP_CHECK);
		ctl.lookup_en = (state_q == ctt_pkg::FSM_EXEC) && (op_q == ctt_pkg::OP_LOOKUP);
		ctl.compact_en = (state_q == ctt_pkg::FSM_COMPACT);
		new_row.src_ip = cmd_q.src_ip;
		new_row.dst_ip = cmd_q.dst_ip;
		new_row.sport = cmd_q.sport;
		new_row.dport = cmd_q.dport;
		new_row.tcp_state = init_q;
		new_row.timestamp = cmd_q.now;
		new_row.rule = rule_q;
	end

	assign slots[TABLE_ROWS] = '0;
	assign fwds[0] = '0;
	assign bwds[TABLE_ROWS] = '0;

	for (genvar i = 0; i < TABLE_ROWS; i++) begin : g_cell
		ctt_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.load     (add_en && (count_q == CW'(i))),
			.load_row (new_row),
			.nxt_slot (slots[i+1]),
			.slot     (slots[i]),
			.fwd_in   (fwds[i]),
			.fwd_out  (fwds[i+1]),
			.bwd_in   (bwds[i+1]),
			.bwd_out  (bwds[i])
		);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ctt_pkg::FSM_IDLE: begin
				if (start) begin
					state_d = ctt_pkg::FSM_EXEC;
				end
			end
			ctt_pkg::FSM_EXEC: begin
				state_d = ctt_pkg::FSM_COMPACT;
			end
			ctt_pkg::FSM_COMPACT: begin
				if (!hole_any) begin
					state_d = ctt_pkg::FSM_IDLE;
				end
			end
			default: begin
				state_d = ctt_pkg::FSM_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ctt_pkg::FSM_IDLE;
			count_q <= '0;
			done_q <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q <= (state_q == ctt_pkg::FSM_COMPACT) && !hole_any;
			if (add_en) begin
				count_q <= count_q + CW'(1);
			end else if ((state_q == ctt_pkg::FSM_COMPACT) && hole_any) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			op_q <= op;
			init_q <= initial_state;
			rule_q <= rule_index;
			cmd_q.check_en <= 1'b0;
			cmd_q.lookup_en <= 1'b0;
			cmd_q.compact_en <= 1'b0;
			cmd_q.plain <= !ctt_pkg::well_known(sport) && !ctt_pkg::well_known(dport);
			cmd_q.syn <= syn_flag;
			cmd_q.fin <= fin_flag;
			cmd_q.rst <= rst_flag;
			cmd_q.direction <= direction;
			cmd_q.src_ip <= src_ip;
			cmd_q.dst_ip <= dst_ip;
			cmd_q.sport <= sport;
			cmd_q.dport <= dport;
			cmd_q.now <= now_seconds;
		end
		if (state_q == ctt_pkg::FSM_EXEC) begin
			verdict_q <= 1'b0;
			rule_out_q <= 8'd0;
			open_q <= 1'b0;
			status_q <= ctt_pkg::STATUS_OK;
			peer_ip_q <= 32'd0;
			peer_port_q <= 16'd0;
			unique case (op_q)
				ctt_pkg::OP_ADD: begin
					if (full) begin
						status_q <= ctt_pkg::STATUS_FULL;
					end
				end
				ctt_pkg::OP_CHECK: begin
					if (bwds[0].act_later) begin
						verdict_q <= 1'b1;
						rule_out_q <= bwds[0].rule_acc;
						open_q <= fwds[TABLE_ROWS].open_acc;
					end
				end
				ctt_pkg::OP_LOOKUP: begin
					if (fwds[TABLE_ROWS].found_pre) begin
						peer_ip_q <= fwds[TABLE_ROWS].peer_ip;
						peer_port_q <= fwds[TABLE_ROWS].peer_port;
					end else begin
						status_q <= ctt_pkg::STATUS_NOTFOUND;
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign done = done_q;
	assign verdict = verdict_q;
	assign matched_rule = rule_out_q;
	assign open_data = open_q;
	assign status = status_q;
	assign peer_ip = peer_ip_q;
	assign peer_port = peer_port_q;
	assign row_count = 7'(count_q);

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(TABLE_ROWS))
		else $error("row count above table size");
	a_done_after_compact: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ctt_pkg::FSM_COMPACT && !hole_any) |=> done_q)
		else $error("missing done after compaction");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (state_q == ctt_pkg::FSM_IDLE))
		else $error("done while busy");
	a_shift_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ctt_pkg::FSM_COMPACT && hole_any) |=> (count_q == $past(count_q) - CW'(1)))
		else $error("compaction did not shrink the table");

endmodule

// ===== bench/testbench.sv =====
// Self-checking testbench for the TCP connection tracking table.
// Drives add, check, lookup and reserved words with random gaps and compares every result
// against an in-bench model of the table. Depends on ctt_pkg and the block.
module testbench;

	typedef struct {
		logic        verdict;
		logic [7:0]  matched_rule;
		logic        open_data;
		logic [1:0]  status;
		logic [31:0] peer_ip;
		logic [15:0] peer_port;
		logic [6:0]  row_count;
	} verdict_t;

	typedef struct {
		logic [1:0]  op;
		logic [31:0] sip;
		logic [31:0] dip;
		logic [15:0] sp;
		logic [15:0] dp;
		logic        syn;
		logic        fin;
		logic        rst;
		logic [2:0]  init;
		logic [7:0]  rule;
		logic [31:0] now;
		logic        dir;
	} word_t;

	class conn_table_sb;
		ctt_pkg::row_t rows[$];
		verdict_t pending[$];
		int errors;

		function void note_word(word_t w);
			verdict_t r;
			ctt_pkg::row_t nr;
			int i;
			bit fwd, rev, plain, sy, fi, none, acted, hit, found;
			logic [2:0] st;
			r = '{default: 0};
			if (w.op == ctt_pkg::OP_ADD) begin
				if (rows.size() >= ctt_pkg::TABLE_ROWS_DEF) r.status = ctt_pkg::STATUS_FULL;
				else begin
					nr.src_ip = w.sip; nr.dst_ip = w.dip;
					nr.sport = w.sp; nr.dport = w.dp;
					nr.tcp_state = w.init; nr.timestamp = w.now; nr.rule = w.rule;
					rows.push_back(nr);
				end
			end else if (w.op == ctt_pkg::OP_CHECK) begin
				hit = 0;
				plain = !(w.sp inside {ctt_pkg::PORT_HTTP, ctt_pkg::PORT_FTP,
					ctt_pkg::PORT_FTP_DATA, ctt_pkg::PORT_SMTP}) &&
					!(w.dp inside {ctt_pkg::PORT_HTTP, ctt_pkg::PORT_FTP,
					ctt_pkg::PORT_FTP_DATA, ctt_pkg::PORT_SMTP});
				sy = w.syn && !w.fin;
				fi = w.fin && !w.syn;
				none = !w.syn && !w.fin;
				i = 0;
				while (i < rows.size()) begin
					fwd = rows[i].src_ip == w.sip && rows[i].dst_ip == w.dip &&
						rows[i].sport == w.sp && rows[i].dport == w.dp;
					rev = rows[i].src_ip == w.dip && rows[i].dst_ip == w.sip &&
						rows[i].sport == w.dp && rows[i].dport == w.sp;
					if (fwd && !rev && rows[i].tcp_state == ctt_pkg::ST_CLOSED) begin
						rows.delete(i);
						continue;
					end
					if (fwd || (plain && rev)) begin
						acted = 0;
						if (w.rst) begin
							rows[i].tcp_state = ctt_pkg::ST_CLOSED;
							acted = 1;
						end
						st = rows[i].tcp_state;
						if (st == ctt_pkg::ST_EXPECTED_FTP && sy) begin
							rows[i].tcp_state = ctt_pkg::ST_SYN_SENT; acted = 1;
						end else if (st == ctt_pkg::ST_SYN_SENT && sy) begin
							rows[i].tcp_state = ctt_pkg::ST_SYNACK; acted = 1;
						end else if (st == ctt_pkg::ST_SYNACK && none) begin
							rows[i].tcp_state = ctt_pkg::ST_ESTABLISHED; acted = 1;
						end else if (st == ctt_pkg::ST_ESTABLISHED && fi) begin
							rows[i].tcp_state = ctt_pkg::ST_FINWAIT; acted = 1;
						end else if ((st == ctt_pkg::ST_FINWAIT || st == ctt_pkg::ST_FINWAIT2)
								&& fi) begin
							rows[i].tcp_state = ctt_pkg::ST_FINACK; acted = 1;
						end else if (st == ctt_pkg::ST_FINWAIT && none) begin
							rows[i].tcp_state = ctt_pkg::ST_FINWAIT2; acted = 1;
						end else if (st == ctt_pkg::ST_FINACK && none) begin
							rows[i].tcp_state = ctt_pkg::ST_CLOSED; acted = 1;
						end else if (st == ctt_pkg::ST_ESTABLISHED && none) begin
							r.open_data = 1; acted = 1;
						end
						if (acted) begin
							rows[i].timestamp = w.now;
							r.matched_rule = rows[i].rule;
							hit = 1;
						end
					end
					i++;
				end
				if (hit) r.verdict = 1;
				else begin
					r.matched_rule = 0; r.open_data = 0;
				end
			end else if (w.op == ctt_pkg::OP_LOOKUP) begin
				found = 0;
				for (i = 0; i < rows.size() && !found; i++) begin
					if (w.dir && rows[i].dst_ip == w.sip && rows[i].dport == w.sp) begin
						r.peer_ip = rows[i].src_ip; r.peer_port = rows[i].sport; found = 1;
					end else if (!w.dir && rows[i].src_ip == w.sip &&
							rows[i].sport == w.sp) begin
						r.peer_ip = rows[i].dst_ip; r.peer_port = rows[i].dport; found = 1;
					end
				end
				if (!found) r.status = ctt_pkg::STATUS_NOTFOUND;
			end
			r.row_count = 7'(rows.size());
			pending.push_back(r);
		endfunction

		function void check_result(verdict_t a);
			verdict_t e;
			if (pending.size() == 0) begin
				$error("result with no word outstanding");
				errors++;
				return;
			end
			e = pending.pop_front();
			if (a.verdict !== e.verdict) begin
				$error("verdict exp %0d got %0d", e.verdict, a.verdict); errors++;
			end
			if (a.matched_rule !== e.matched_rule) begin
				$error("matched_rule exp %0d got %0d", e.matched_rule, a.matched_rule); errors++;
			end
			if (a.open_data !== e.open_data) begin
				$error("open_data exp %0d got %0d", e.open_data, a.open_data); errors++;
			end
			if (a.status !== e.status) begin
				$error("status exp %0d got %0d", e.status, a.status); errors++;
			end
			if (a.peer_ip !== e.peer_ip) begin
				$error("peer_ip exp %h got %h", e.peer_ip, a.peer_ip); errors++;
			end
			if (a.peer_port !== e.peer_port) begin
				$error("peer_port exp %h got %h", e.peer_port, a.peer_port); errors++;
			end
			if (a.row_count !== e.row_count) begin
				$error("row_count exp %0d got %0d", e.row_count, a.row_count); errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic [1:0] op = 0;
	logic [31:0] src_ip = 0, dst_ip = 0, now_seconds = 0;
	logic [15:0] sport = 0, dport = 0;
	logic syn_flag = 0, fin_flag = 0, rst_flag = 0, direction = 0;
	logic [2:0] initial_state = 0;
	logic [7:0] rule_index = 0;
	logic busy, done, verdict, open_data;
	logic [7:0] matched_rule;
	logic [1:0] status;
	logic [31:0] peer_ip;
	logic [15:0] peer_port;
	logic [6:0] row_count;

	conn_table_sb sb = new();
	logic [31:0] ip_pool[8];
	logic [15:0] port_pool[8];

	tcp_connection_tracking_table dut (.*);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_result('{verdict, matched_rule, open_data, status, peer_ip, peer_port,
				row_count});
	end

	function automatic int gap_len();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
	endfunction

	task automatic send_word(word_t w);
		int n;
		op <= w.op; src_ip <= w.sip; dst_ip <= w.dip; sport <= w.sp; dport <= w.dp;
		syn_flag <= w.syn; fin_flag <= w.fin; rst_flag <= w.rst;
		initial_state <= w.init; rule_index <= w.rule; now_seconds <= w.now;
		direction <= w.dir;
		start <= 1;
		do @(posedge clk); while (busy);
		sb.note_word(w);
		n = ($urandom_range(0, 2) != 0) ? gap_len() : 0;
		if (n > 0) begin
			start <= 0;
			repeat (n) @(posedge clk);
		end
	endtask

	function automatic word_t make_word(logic [1:0] o);
		word_t w;
		w.op = o;
		w.sip = ip_pool[$urandom_range(0, 7)];
		w.dip = ip_pool[$urandom_range(0, 7)];
		w.sp = port_pool[$urandom_range(0, 7)];
		w.dp = port_pool[$urandom_range(0, 7)];
		w.syn = 1'($urandom); w.fin = 1'($urandom); w.rst = ($urandom_range(0, 9) == 0);
		w.init = 3'($urandom); w.rule = 8'($urandom); w.now = $urandom;
		w.dir = 1'($urandom);
		return w;
	endfunction

	function automatic word_t swap_ends(word_t w);
		word_t s;
		s = w;
		s.sip = w.dip; s.dip = w.sip; s.sp = w.dp; s.dp = w.sp;
		return s;
	endfunction

	initial begin
		word_t w, p;
		int k, j, sent;
		ip_pool = '{32'h0, 32'hFFFF_FFFF, 32'h0A00_0001, 32'h0A00_0002, 32'hC0A8_0101,
			32'h8000_0000, 32'h7FFF_FFFF, 32'h5555_AAAA};
		port_pool = '{16'd0, 16'hFFFF, 16'd80, 16'd21, 16'd20, 16'd25, 16'd5000, 16'hAAAA};
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		w = make_word(ctt_pkg::OP_LOOKUP);
		send_word(w);
		w = make_word(ctt_pkg::OP_CHECK);
		send_word(w);
		w = '{ctt_pkg::OP_ADD, 32'h0A00_0001, 32'h0A00_0002, 16'd5000, 16'hFFFF, 0, 0, 0,
			ctt_pkg::ST_EXPECTED_FTP, 8'hFF, 32'hFFFF_FFFF, 0};
		p = w;
		send_word(w);
		w.op = ctt_pkg::OP_CHECK; w.syn = 1; send_word(w);
		w = swap_ends(w); send_word(w);
		w.syn = 0; send_word(w);
		send_word(w);
		w.fin = 1; send_word(w);
		w.fin = 0; send_word(w);
		w.fin = 1; send_word(w);
		w.fin = 0; send_word(w);
		w = p; w.op = ctt_pkg::OP_ADD; w.init = ctt_pkg::ST_CLOSED; w.rule = 0; send_word(w);
		w.op = ctt_pkg::OP_CHECK; send_word(w);
		w = p; w.op = ctt_pkg::OP_LOOKUP; w.dir = 1; w.sip = p.dip; w.sp = p.dp; send_word(w);
		w = p; w.op = ctt_pkg::OP_LOOKUP; w.dir = 0; send_word(w);
		w = p; w.op = ctt_pkg::OP_CHECK; w.rst = 1; w.syn = 1; w.fin = 1; send_word(w);
		w = p; w.op = ctt_pkg::OP_RESERVED; w.rst = 1; send_word(w);
		for (k = 0; k < 66; k++) begin
			w = make_word(ctt_pkg::OP_ADD);
			send_word(w);
		end
		while (sb.rows.size() > 0) begin
			w = make_word(ctt_pkg::OP_CHECK);
			w.sip = sb.rows[0].src_ip; w.dip = sb.rows[0].dst_ip;
			w.sp = sb.rows[0].sport; w.dp = sb.rows[0].dport;
			w.rst = 1;
			send_word(w);
			w.rst = 0; w.syn = 0; w.fin = 0;
			send_word(w);
			if (sb.rows.size() > 0 && w.sip == w.dip && w.sp == w.dp) begin
				break;
			end
		end
		sent = 0;
		while (sent < 1150) begin
			k = $urandom_range(0, 19);
			if (k < 3) begin
				w = make_word(ctt_pkg::OP_ADD);
				if (sb.rows.size() > 40) w.op = ctt_pkg::OP_CHECK;
				send_word(w);
				sent++;
				p = w;
				for (j = 0; j < 6 && sent < 1150; j++) begin
					w = make_word(ctt_pkg::OP_CHECK);
					w.sip = p.sip; w.dip = p.dip; w.sp = p.sp; w.dp = p.dp;
					if ($urandom_range(0, 1)) w = swap_ends(w);
					send_word(w);
					sent++;
				end
			end else if (k < 5) begin
				w = make_word(ctt_pkg::OP_LOOKUP);
				if (sb.rows.size() > 0 && $urandom_range(0, 1)) begin
					j = $urandom_range(0, sb.rows.size() - 1);
					w.sip = w.dir ? sb.rows[j].dst_ip : sb.rows[j].src_ip;
					w.sp = w.dir ? sb.rows[j].dport : sb.rows[j].sport;
				end
				send_word(w);
				sent++;
			end else if (k == 5) begin
				w = make_word(2'($urandom_range(0, 3)));
				w.sip = $urandom; w.dip = $urandom; w.sp = 16'($urandom); w.dp = 16'($urandom);
				send_word(w);
				sent++;
			end else begin
				w = make_word(ctt_pkg::OP_CHECK);
				if (sb.rows.size() > 0) begin
					j = $urandom_range(0, sb.rows.size() - 1);
					w.sip = sb.rows[j].src_ip; w.dip = sb.rows[j].dst_ip;
					w.sp = sb.rows[j].sport; w.dp = sb.rows[j].dport;
					if ($urandom_range(0, 2) == 0) w = swap_ends(w);
				end
				send_word(w);
				sent++;
			end
		end
		start <= 0;
		k = 0;
		while (sb.pending.size() > 0 && k < 10000) begin
			@(posedge clk);
			k++;
		end
		repeat (80) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin
		#2000000;
		$display("simulation failed");
		$finish;
	end
endmodule
